// ===== rtl/core/pcaoc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaoc_pkg
// Shared constants and types of the phase current averager with offset
// calibration: channel counts, field widths, the phase table entry layout.
// ----------------------------------------------------------------------------
package pcaoc_pkg;

  // scan and buffer sizing
  localparam int SAMPLES_PER_CHANNEL = 16;
  localparam int SAMPLE_BITS         = 12;
  localparam int NUM_RANKS           = 5;
  localparam int NUM_PHASES          = 3;
  localparam int RANK_TEMP           = 3;
  localparam int RANK_BUS            = 4;

  // field widths
  localparam int VALUE_W  = 12;
  localparam int PHASE_W  = 2;
  localparam int ROUND_W  = 8;
  localparam int RANK_W   = 3;
  localparam int BSUM_W   = 20;
  localparam int SUM_W    = 28;
  localparam int COUNT_W  = 16;
  localparam int CALRD_W  = 8;
  localparam int CFG_W    = 8;

  localparam int BUF_AW   = $clog2(NUM_RANKS);
  localparam int PH_AW    = $clog2(NUM_PHASES);
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [VALUE_W-1:0] SAMPLE_MASK = VALUE_W'((33'd1 << SAMPLE_BITS) - 33'd1);
  localparam logic [CFG_W-1:0]   CAL_RESET   = 8'd17;

  // opcodes and result kinds
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_READ     = 1'b1;
  localparam logic KIND_BUFFER = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // tdata layout widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // one entry of the phase table
  typedef struct packed {
    logic [CALRD_W-1:0] cal_reads;
    logic [VALUE_W-1:0] offset;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } phase_entry_t;

  localparam int PH_ENTRY_W = $bits(phase_entry_t);

  // result item waiting for the output register
  typedef struct packed {
    logic               kind;
    logic [PHASE_W-1:0] phase_id;
    logic [VALUE_W-1:0] current;
    logic               calibrating;
    logic               empty_read;
  } result_t;

endpackage

// ===== rtl/core/pcaoc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaoc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pcaoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/pcaoc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaoc_div
// Restoring bit-serial divider: running sum by buffer count, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module pcaoc_div
  import pcaoc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [SUM_W-1:0]   quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0]   rem_r;
  logic [COUNT_W-1:0]   dvs_r;
  logic [SUM_W-1:0]     quo_r;
  logic [COUNT_W:0]     trial;
  logic                 fits;

  // trial subtraction of the shifted remainder
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // datapath: the dividend shifts out as the quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? COUNT_W'(trial - {1'b0, dvs_r}) : trial[COUNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/phase_current_averager_offset_cal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_current_averager_offset_cal
// ADC scan averager with per-phase running means and zero-current offset
// calibration, built around a channel sum memory and a phase table memory.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A sample that does not close a buffer
// goes through a memory read, then an add and write back. After the sample
// that closes a buffer, the three phase table entries are updated one per
// cycle through the single memory write port, then the temperature sum is read.
// A phase read waits on the 28-bit bit-serial divider, which produces one
// quotient bit per cycle; an empty read skips the divider. A result leaves
// through an output register, and the block waits only when that register is
// still full. Reset takes effect at once through per-entry valid bits; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module phase_current_averager_offset_cal
  import pcaoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_value[11:0], phase_select[13:12]
  input  logic                  in_tuser,   // opcode[0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // phase_id[1:0], current_counts[13:2],
                                            // calibrating[14], empty_read[15],
                                            // bus_voltage_mean[27:16],
                                            // temperature_mean[39:28]
  output logic                  out_tuser,  // result_kind[0]
  // calibration_reads register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SMP  = 4'd1;
  localparam logic [3:0] ST_FWR  = 4'd2;
  localparam logic [3:0] ST_FTMP = 4'd3;
  localparam logic [3:0] ST_RDC  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_RWR  = 4'd6;
  localparam logic [3:0] ST_EMIT = 4'd7;

  logic [3:0]              state_r;
  logic [RANK_W-1:0]       rank_r;
  logic [ROUND_W-1:0]      round_r;
  logic [NUM_RANKS-1:0]    bvalid_r;
  logic [NUM_PHASES-1:0]   pvalid_r;
  logic [CFG_W-1:0]        calib_r;
  logic [VALUE_W-1:0]      bus_r;
  logic [VALUE_W-1:0]      temp_r;
  logic [VALUE_W-1:0]      sample_r;
  logic [PH_AW-1:0]        ph_r;
  logic [PH_AW-1:0]        idx_r;
  logic [BUF_AW-1:0]       baddr_r;
  logic [PH_AW-1:0]        paddr_r;
  phase_entry_t            ent_r;
  result_t                 res_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_user_r;

  logic                    in_fire;
  logic                    in_opcode;
  logic [VALUE_W-1:0]      in_sample;
  logic [PHASE_W-1:0]      in_phase;
  logic                    in_phase_ok;
  logic [BUF_AW-1:0]       rank_sel;

  logic                    buf_we;
  logic [BUF_AW-1:0]       buf_waddr;
  logic [BSUM_W-1:0]       buf_wdata;
  logic [BUF_AW-1:0]       buf_raddr;
  logic [BSUM_W-1:0]       buf_rdata;
  logic                    ph_we;
  logic [PH_AW-1:0]        ph_waddr;
  phase_entry_t            ph_wdata;
  logic [PH_AW-1:0]        ph_raddr;
  logic [PH_ENTRY_W-1:0]   ph_rdata;

  logic [BSUM_W-1:0]       bsum_old;
  logic [BSUM_W-1:0]       bsum_new;
  logic [BSUM_W-1:0]       mean_old;
  logic [BSUM_W-1:0]       mean_new;
  phase_entry_t            pent;
  phase_entry_t            pent_acc;
  logic                    last_rank;
  logic                    last_round;

  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quot;
  logic [VALUE_W-1:0]      quot;
  logic                    cal_now;
  logic [VALUE_W-1:0]      off_new;
  logic [VALUE_W-1:0]      cur_new;
  logic                    out_free;

  // input fields
  assign in_opcode   = in_tuser;
  assign in_sample   = in_tdata[VALUE_W-1:0] & SAMPLE_MASK;
  assign in_phase    = in_tdata[VALUE_W +: PHASE_W];
  assign in_phase_ok = (in_phase < PHASE_W'(NUM_PHASES));
  assign in_tready   = (state_r == ST_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;
  assign rank_sel    = (rank_r >= RANK_W'(NUM_RANKS)) ? '0 : BUF_AW'(rank_r);

  // memory read data, entries never written since reset or clear read as zero
  assign bsum_old = bvalid_r[baddr_r] ? buf_rdata : '0;
  assign pent     = pvalid_r[paddr_r] ? phase_entry_t'(ph_rdata) : '0;
  assign bsum_new = BSUM_W'(bsum_old + BSUM_W'(sample_r));
  assign mean_old = BSUM_W'(bsum_old / SAMPLES_PER_CHANNEL);
  assign mean_new = BSUM_W'(bsum_new / SAMPLES_PER_CHANNEL);

  assign last_rank  = (baddr_r == BUF_AW'(RANK_BUS));
  assign last_round = (round_r == ROUND_W'(SAMPLES_PER_CHANNEL - 1));

  // phase entry after adding one buffer mean, count saturates
  always_comb begin
    pent_acc = pent;
    if (pent.count != '1) begin
      pent_acc.sum   = SUM_W'(pent.sum + SUM_W'(mean_old));
      pent_acc.count = pent.count + 1'b1;
    end
  end

  // read answer: offset capture and clamped subtraction
  assign quot    = div_quot[VALUE_W-1:0];
  assign cal_now = (ent_r.cal_reads < calib_r);
  assign off_new = cal_now ? quot : ent_r.offset;
  assign cur_new = (quot > off_new) ? (quot - off_new) : '0;

  // memory addressing and write ports
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = baddr_r;
    buf_wdata = bsum_new;
    ph_we     = 1'b0;
    ph_waddr  = idx_r;
    ph_wdata  = pent_acc;
    buf_raddr = '0;
    ph_raddr  = '0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        buf_raddr = rank_sel;
        ph_raddr  = in_phase_ok ? PH_AW'(in_phase) : '0;
      end
      ST_SMP: begin
        buf_we = 1'b1;
      end
      ST_FWR: begin
        ph_we     = 1'b1;
        buf_raddr = BUF_AW'(idx_r) + 1'b1;
        ph_raddr  = (idx_r == PH_AW'(NUM_PHASES - 1)) ? '0 : idx_r + 1'b1;
      end
      ST_RDC: begin
        div_start = (pent.count != '0);
      end
      ST_RWR: begin
        ph_we              = 1'b1;
        ph_waddr           = ph_r;
        ph_wdata.sum       = '0;
        ph_wdata.count     = '0;
        ph_wdata.offset    = off_new;
        ph_wdata.cal_reads = cal_now ? ent_r.cal_reads + 1'b1 : ent_r.cal_reads;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rank_r   <= '0;
      round_r  <= '0;
      bvalid_r <= '0;
      pvalid_r <= '0;
      calib_r  <= CAL_RESET;
      bus_r    <= '0;
      temp_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        calib_r <= cfg_data;
      end
      if (buf_we) begin
        bvalid_r[buf_waddr] <= 1'b1;
      end
      if (ph_we) begin
        pvalid_r[ph_waddr] <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_opcode == OP_SAMPLE) begin
              state_r <= ST_SMP;
            end else if (in_phase_ok) begin
              state_r <= ST_RDC;
            end
          end
        end
        ST_SMP: begin
          if (!last_rank) begin
            rank_r  <= RANK_W'(baddr_r) + 1'b1;
            state_r <= ST_IDLE;
          end else if (!last_round) begin
            rank_r  <= '0;
            round_r <= round_r + 1'b1;
            state_r <= ST_IDLE;
          end else begin
            rank_r  <= '0;
            round_r <= '0;
            bus_r   <= mean_new[VALUE_W-1:0];
            state_r <= ST_FWR;
          end
        end
        ST_FWR: begin
          if (idx_r == PH_AW'(NUM_PHASES - 1)) begin
            state_r <= ST_FTMP;
          end
        end
        ST_FTMP: begin
          temp_r   <= mean_old[VALUE_W-1:0];
          bvalid_r <= '0;
          state_r  <= ST_EMIT;
        end
        ST_RDC: begin
          state_r <= (pent.count == '0) ? ST_EMIT : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_RWR;
          end
        end
        ST_RWR: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // working registers without reset
  always_ff @(posedge clk) begin
    baddr_r <= buf_raddr;
    paddr_r <= ph_raddr;
    case (state_r)
      ST_IDLE: begin
        sample_r <= in_sample;
        ph_r     <= in_phase_ok ? PH_AW'(in_phase) : '0;
      end
      ST_SMP: begin
        idx_r <= '0;
      end
      ST_FWR: begin
        idx_r <= idx_r + 1'b1;
      end
      ST_FTMP: begin
        res_r <= '{kind: KIND_BUFFER, phase_id: '0, current: '0,
                   calibrating: 1'b0, empty_read: 1'b0};
      end
      ST_RDC: begin
        ent_r <= pent;
        res_r <= '{kind: KIND_READ, phase_id: PHASE_W'(ph_r), current: '0,
                   calibrating: 1'b0, empty_read: 1'b1};
      end
      ST_RWR: begin
        res_r <= '{kind: KIND_READ, phase_id: PHASE_W'(ph_r), current: cur_new,
                   calibrating: cal_now, empty_read: 1'b0};
      end
      default: begin
      end
    endcase
  end

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_user_r <= res_r.kind;
      out_data_r <= {temp_r, bus_r, res_r.empty_read, res_r.calibrating,
                     res_r.current, res_r.phase_id};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // channel buffer sums
  pcaoc_ram #(
    .WIDTH (BSUM_W),
    .DEPTH (NUM_RANKS)
  ) u_buf_ram (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (buf_waddr),
    .wr_data (buf_wdata),
    .rd_addr (buf_raddr),
    .rd_data (buf_rdata)
  );

  // phase table: running sum, count, offset, calibration reads
  pcaoc_ram #(
    .WIDTH (PH_ENTRY_W),
    .DEPTH (NUM_PHASES)
  ) u_phase_ram (
    .clk     (clk),
    .wr_en   (ph_we),
    .wr_addr (ph_waddr),
    .wr_data (ph_wdata),
    .rd_addr (ph_raddr),
    .rd_data (ph_rdata)
  );

  // running sum divided by buffer count
  pcaoc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pent.sum),
    .divisor  (pent.count),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

// ===== tb/tb_phase_current_averager_offset_cal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phase_current_averager_offset_cal
// Self-checking bench for the phase current averager. An in-bench model of
// the scan buffers, phase running sums and offset capture predicts every
// result. Samples and phase reads are streamed in with random gaps, the result
// side stalls at random, and the calibration_reads register is swept.
// ----------------------------------------------------------------------------
module tb_phase_current_averager_offset_cal;
  import pcaoc_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = 48;
  localparam int IDLE_PCT     = 26;
  localparam int MAX_REPORTS  = 10;

  localparam logic [PHASE_W-1:0] PH_U    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_V    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_W    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_NONE = 2'd3;

  // one result item, unpacked from the output stream
  typedef struct packed {
    logic               kind;
    logic [PHASE_W-1:0] phase;
    logic [VALUE_W-1:0] current;
    logic               calibrating;
    logic               empty_read;
    logic [VALUE_W-1:0] bus_mean;
    logic [VALUE_W-1:0] temp_mean;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // sample_value[11:0], phase_select[13:12]
  logic                  in_tuser = 1'b0; // opcode[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // phase_id[1:0], current_counts[13:2],
                                          // calibrating[14], empty_read[15],
                                          // bus_voltage_mean[27:16],
                                          // temperature_mean[39:28]
  logic                  out_tuser;       // result_kind[0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  // bench control
  logic no_idle  = 1'b0;
  logic hold_off = 1'b0;
  int   cycle_count = 0;
  int   mismatch_count = 0;

  answer_t pending_answers[$];

  // model state
  logic [CFG_W-1:0]   cal_limit;
  logic [RANK_W-1:0]  scan_rank;
  logic [ROUND_W-1:0] scan_round;
  logic [BSUM_W-1:0]  chan_sum[NUM_RANKS];
  logic [SUM_W-1:0]   run_sum[NUM_PHASES];
  logic [COUNT_W-1:0] buf_count[NUM_PHASES];
  logic [VALUE_W-1:0] offset[NUM_PHASES];
  logic [CALRD_W-1:0] cal_taken[NUM_PHASES];
  logic [VALUE_W-1:0] bus_latch;
  logic [VALUE_W-1:0] temp_latch;

  phase_current_averager_offset_cal dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    out_tready <= !hold_off && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[1:0], out_tdata[13:2], out_tdata[14], out_tdata[15],
             out_tdata[27:16], out_tdata[39:28]};
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: kind %0d phase %0d current %0d", got.kind,
                   got.phase, got.current);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected kind %0d phase %0d current %0d cal %0d empty %0d bus %0d temp %0d",
                     want.kind, want.phase, want.current, want.calibrating,
                     want.empty_read, want.bus_mean, want.temp_mean);
            $display("  actual   kind %0d phase %0d current %0d cal %0d empty %0d bus %0d temp %0d",
                     got.kind, got.phase, got.current, got.calibrating,
                     got.empty_read, got.bus_mean, got.temp_mean);
          end
        end
      end
    end
  end

  task automatic reset_model();
    cal_limit  = CAL_RESET;
    scan_rank  = '0;
    scan_round = '0;
    for (int i = 0; i < NUM_RANKS; i++) chan_sum[i] = '0;
    for (int i = 0; i < NUM_PHASES; i++) begin
      run_sum[i]   = '0;
      buf_count[i] = '0;
      offset[i]    = '0;
      cal_taken[i] = '0;
    end
    bus_latch  = '0;
    temp_latch = '0;
  endtask

  // advance the model by one accepted input and queue the answer it causes
  task automatic predict_answer(input logic op, input logic [VALUE_W-1:0] smp,
                                input logic [PHASE_W-1:0] ph);
    answer_t      ans;
    logic [SUM_W-1:0]   quot;
    logic [VALUE_W-1:0] q;
    logic [BSUM_W-1:0]  mean;
    ans = '0;
    if (op == OP_SAMPLE) begin
      chan_sum[scan_rank] = chan_sum[scan_rank] + (smp & SAMPLE_MASK);
      if (scan_rank != NUM_RANKS - 1) begin
        scan_rank = scan_rank + 1'b1;
      end else begin
        scan_rank = '0;
        if (scan_round + 1 < SAMPLES_PER_CHANNEL) begin
          scan_round = scan_round + 1'b1;
        end else begin
          // buffer closes: fold phase means, latch temperature and bus
          scan_round = '0;
          for (int i = 0; i < NUM_PHASES; i++) begin
            mean = chan_sum[i] / SAMPLES_PER_CHANNEL;
            if (buf_count[i] != '1) begin
              run_sum[i]   = run_sum[i] + mean;
              buf_count[i] = buf_count[i] + 1'b1;
            end
          end
          mean       = chan_sum[RANK_TEMP] / SAMPLES_PER_CHANNEL;
          temp_latch = mean[VALUE_W-1:0];
          mean       = chan_sum[RANK_BUS] / SAMPLES_PER_CHANNEL;
          bus_latch  = mean[VALUE_W-1:0];
          for (int i = 0; i < NUM_RANKS; i++) chan_sum[i] = '0;
          ans.kind      = KIND_BUFFER;
          ans.bus_mean  = bus_latch;
          ans.temp_mean = temp_latch;
          pending_answers.push_back(ans);
        end
      end
    end else if (ph != PH_NONE) begin
      ans.kind      = KIND_READ;
      ans.phase     = ph;
      ans.bus_mean  = bus_latch;
      ans.temp_mean = temp_latch;
      if (buf_count[ph] == '0) begin
        ans.empty_read = 1'b1;
      end else begin
        quot = run_sum[ph] / buf_count[ph];
        q    = quot[VALUE_W-1:0];
        run_sum[ph]   = '0;
        buf_count[ph] = '0;
        if (cal_taken[ph] < cal_limit) begin
          offset[ph]      = q;
          cal_taken[ph]   = cal_taken[ph] + 1'b1;
          ans.calibrating = 1'b1;
        end
        ans.current = (q > offset[ph]) ? q - offset[ph] : '0;
      end
      pending_answers.push_back(ans);
    end
  endtask

  // offer one item, with a random gap first, and wait for the transaction
  task automatic send_item(input logic op, input logic [VALUE_W-1:0] smp,
                           input logic [PHASE_W-1:0] ph);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, ph, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_answer(op, smp, ph);
  endtask

  // stop offering, let every answer arrive and the block go quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cal_reads(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cal_limit = value;
  endtask

  // scan traffic: samples around per-buffer channel levels, reads mixed in
  task automatic run_scan_traffic(input int items, input int read_pct);
    logic [VALUE_W-1:0] level[NUM_RANKS];
    logic [VALUE_W-1:0] v;
    logic [PHASE_W-1:0] ph;
    int                 tmp;
    for (int i = 0; i < NUM_RANKS; i++) level[i] = VALUE_W'($urandom);
    for (int n = 0; n < items; n++) begin
      if (scan_rank == 0 && scan_round == 0)
        for (int i = 0; i < NUM_RANKS; i++) level[i] = VALUE_W'($urandom);
      if ($urandom_range(0, 99) < read_pct) begin
        ph = ($urandom_range(0, 15) == 0) ? PH_NONE : PHASE_W'($urandom_range(0, 2));
        send_item(OP_READ, VALUE_W'($urandom), ph);
      end else begin
        case ($urandom_range(0, 9))
          0: v = VALUE_W'($urandom);
          1: v = $urandom_range(0, 1) ? '1 : '0;
          default: begin
            tmp = int'(level[scan_rank]) + $urandom_range(0, 128) - 64;
            if (tmp < 0) tmp = 0;
            if (tmp > 4095) tmp = 4095;
            v = VALUE_W'(tmp);
          end
        endcase
        send_item(OP_SAMPLE, v, PHASE_W'($urandom));
      end
    end
  endtask

  // empty reads, ignored phase, sample extremes in a partial scan
  task automatic test_directed();
    send_item(OP_READ, '0, PH_U);
    send_item(OP_READ, '1, PH_V);
    send_item(OP_READ, '0, PH_W);
    send_item(OP_READ, '1, PH_NONE);
    send_item(OP_SAMPLE, '1, PH_NONE);
    send_item(OP_SAMPLE, '0, PH_U);
    send_item(OP_SAMPLE, 12'h800, PH_V);
    send_item(OP_SAMPLE, 12'h7FF, PH_W);
    send_item(OP_SAMPLE, 12'h001, PH_NONE);
    send_item(OP_SAMPLE, 12'hAAA, PH_U);
    send_item(OP_SAMPLE, 12'h555, PH_V);
    send_item(OP_READ, 12'hFFF, PH_U);
    send_item(OP_SAMPLE, '1, PH_W);
    send_item(OP_SAMPLE, '1, PH_U);
    send_item(OP_READ, '0, PH_NONE);
  endtask

  // reset value: offsets captured on the first reads
  task automatic test_default_calibration();
    run_scan_traffic(320, 10);
  endtask

  // zero limit, streamed back to back with no gaps on either side
  task automatic test_capture_disabled();
    write_cal_reads(8'd0);
    no_idle = 1'b1;
    run_scan_traffic(260, 10);
    no_idle = 1'b0;
  endtask

  // maximum limit: every non-empty read recaptures the offset
  task automatic test_capture_always();
    write_cal_reads(8'd255);
    run_scan_traffic(240, 12);
  endtask

  // limit lowered below reads already taken: offsets frozen, clamp exercised
  task automatic test_limit_lowered();
    write_cal_reads(8'd1);
    run_scan_traffic(240, 12);
  endtask

  // receiver holds off while reads keep coming, block must stall its input
  task automatic test_result_backpressure();
    write_cal_reads(8'd3);
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int n = 0; n < 30; n++) begin
      if (n % 3 == 2)
        send_item(OP_SAMPLE, VALUE_W'($urandom), PHASE_W'($urandom));
      else
        send_item(OP_READ, VALUE_W'($urandom), PHASE_W'($urandom_range(0, 2)));
    end
    run_scan_traffic(180, 8);
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_default_calibration();
    test_capture_disabled();
    test_capture_always();
    test_limit_lowered();
    test_result_backpressure();
    drain();
    if (pending_answers.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
